/* rtl/core/ckt_pkg.sv */
`default_nettype none

package ckt_pkg;

   typedef logic [2:0] kind_type;
   typedef logic [1:0] op_type;

   localparam op_type OP_ADD    = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_UPDATE = 2'd2;
   localparam op_type OP_TICK   = 2'd3;

   localparam kind_type KIND_DONE = 3'd0;
   localparam kind_type KIND_FAIL = 3'd1;
   localparam kind_type KIND_PING = 3'd2;
   localparam kind_type KIND_DEAD = 3'd3;
   localparam kind_type KIND_NONE = 3'd4;

   localparam logic [1:0] REG_PERIOD = 2'd0;
   localparam logic [1:0] REG_LIMIT  = 2'd1;
   localparam logic [1:0] REG_SLOTS  = 2'd2;

   localparam logic [31:0] PERIOD_RESET = 32'd10000;
   localparam logic [31:0] LIMIT_RESET  = 32'd20000;
   localparam logic [4:0]  SLOTS_RESET  = 5'd12;

   localparam int DEF_TABLE_SLOTS = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int RES_W           = $clog2(MAX_RESULTS + 1);

   localparam int ID_W   = 16;
   localparam int TIME_W = 48;

endpackage

`default_nettype wire

/* rtl/core/connection_keepalive_tracker.sv */
// add, remove, update: each slot walked passes READ and CHK; a hit goes straight to FIN to post the word,
// a miss passes READ once more before FIN; ticks: each slot walked passes READ and CHK, a due slot also LIMIT
// one item at a time: a shared 49-bit add and compare unit checks one slot per step
// a new request is taken only in idle; the walk covers span = min(slots_ff, TABLE_SLOTS) slots, and a tick
// stops once MAX_RESULTS due slots are found; rsp_stall can hold the walk in LIMIT and FIN
// reset: synchronous, clears all slots to free and loads the register defaults
`default_nettype none

module connection_keepalive_tracker #(
   parameter int TABLE_SLOTS = ckt_pkg::DEF_TABLE_SLOTS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_op,
   input  wire logic [ckt_pkg::ID_W-1:0]   req_client_id,
   input  wire logic [ckt_pkg::TIME_W-1:0] req_now_ms,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [2:0]                      rsp_result_kind,
   output logic [ckt_pkg::ID_W-1:0]        rsp_result_client,
   output logic                            rsp_last_result,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [3:0]                 csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import ckt_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_CHK   = 3'd2;
   localparam logic [2:0] S_LIMIT = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   // configuration
   logic [31:0] period_ff;
   logic [31:0] limit_ff;
   logic [4:0]  slots_ff;
   logic        csr_we;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         limit_ff  <= LIMIT_RESET;
         slots_ff  <= SLOTS_RESET;
      end else if (csr_we) begin
         case (csr_paddr[3:2])
            REG_PERIOD: period_ff <= csr_pwdata;
            REG_LIMIT:  limit_ff  <= csr_pwdata;
            REG_SLOTS:  slots_ff  <= csr_pwdata[4:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_PERIOD: csr_prdata = period_ff;
         REG_LIMIT:  csr_prdata = limit_ff;
         REG_SLOTS:  csr_prdata = {27'd0, slots_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   logic [CNT_W-1:0] span;
   assign span = (32'(slots_ff) > 32'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS)
                                                    : CNT_W'(slots_ff);

   // sequencer state
   logic [2:0]        state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [RES_W-1:0]  found_ff, found_in;
   logic              pend_valid_ff, pend_valid_in;
   kind_type          pend_kind_ff, pend_kind_in;
   logic [ID_W-1:0]   pend_client_ff, pend_client_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_client_ff, rsp_client_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [TABLE_SLOTS-1:0] active_ff, active_in;

   // slot memories
   logic [ID_W-1:0]   client_mem [TABLE_SLOTS];
   logic [TIME_W-1:0] seen_mem [TABLE_SLOTS];
   logic [ID_W-1:0]   rd_client_ff;
   logic [TIME_W-1:0] rd_seen_ff;
   logic [IDX_W-1:0]  addr;
   logic              client_we;
   logic              seen_we;

   assign addr = idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (client_we) begin
         client_mem[addr] <= id_ff;
      end
      if (seen_we) begin
         seen_mem[addr] <= now_ff;
      end
      rd_client_ff <= client_mem[addr];
      rd_seen_ff   <= seen_mem[addr];
   end

   // shared add and compare unit
   logic [31:0]     cmp_operand;
   logic [TIME_W:0] cmp_sum;
   logic            cmp_hit;

   assign cmp_operand = (state_ff == S_LIMIT) ? limit_ff : period_ff;
   assign cmp_sum     = {1'b0, rd_seen_ff} + {17'd0, cmp_operand};
   assign cmp_hit     = cmp_sum <= {1'b0, now_ff};

   logic req_accept;
   logic out_free;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      now_in         = now_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_client_in = pend_client_ff;
      active_in      = active_ff;
      client_we      = 1'b0;
      seen_we        = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_client_in  = rsp_client_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_op;
               id_in         = req_client_id;
               now_in        = req_now_ms;
               idx_in        = '0;
               found_in      = '0;
               pend_valid_in = 1'b0;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            if (idx_ff >= span || found_ff == RES_W'(MAX_RESULTS)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            state_in = S_READ;
            idx_in   = idx_ff + 1'b1;
            case (op_ff)
               OP_ADD: begin
                  if (!active_ff[addr]) begin
                     active_in[addr] = 1'b1;
                     client_we       = 1'b1;
                     seen_we         = 1'b1;
                     pend_valid_in   = 1'b1;
                     pend_kind_in    = KIND_DONE;
                     pend_client_in  = id_ff;
                     state_in        = S_FIN;
                  end
               end
               OP_REMOVE, OP_UPDATE: begin
                  if (active_ff[addr] && rd_client_ff == id_ff) begin
                     if (op_ff == OP_REMOVE) begin
                        active_in[addr] = 1'b0;
                     end else begin
                        seen_we = 1'b1;
                     end
                     pend_valid_in  = 1'b1;
                     pend_kind_in   = KIND_DONE;
                     pend_client_in = id_ff;
                     state_in       = S_FIN;
                  end
               end
               default: begin
                  if (active_ff[addr] && cmp_hit) begin
                     idx_in   = idx_ff;
                     state_in = S_LIMIT;
                  end
               end
            endcase
         end
         S_LIMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = pend_kind_ff;
                  rsp_client_in = pend_client_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in  = 1'b1;
               pend_kind_in   = cmp_hit ? KIND_DEAD : KIND_PING;
               pend_client_in = rd_client_ff;
               found_in       = found_ff + 1'b1;
               idx_in         = idx_ff + 1'b1;
               state_in       = S_READ;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  rsp_kind_in   = pend_kind_ff;
                  rsp_client_in = pend_client_ff;
               end else if (op_ff == OP_TICK) begin
                  rsp_kind_in   = KIND_NONE;
                  rsp_client_in = '0;
               end else begin
                  rsp_kind_in   = KIND_FAIL;
                  rsp_client_in = id_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         found_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         active_ff     <= '0;
         op_ff         <= OP_ADD;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         active_ff     <= active_in;
         op_ff         <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff          <= id_in;
      now_ff         <= now_in;
      pend_kind_ff   <= pend_kind_in;
      pend_client_ff <= pend_client_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_client_ff  <= rsp_client_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_result_client = rsp_client_ff;
   assign rsp_last_result   = rsp_last_ff;

   a_found_cap: assert property (@(posedge clock) disable iff (reset)
      found_ff <= RES_W'(MAX_RESULTS))
      else $error("due count beyond cap");

   a_chk_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK || state_ff == S_LIMIT) |-> idx_ff < span)
      else $error("slot walk beyond span");

   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=>
         (state_ff == S_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("scan finished without final word");

   a_mid_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> op_ff == OP_TICK)
      else $error("non-final word outside a tick");

endmodule

`default_nettype wire
